// ===== sv/tbng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tbng_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 17;
  localparam int MA_W       = 33;
  localparam int MB_W       = 27;
  localparam int P_W        = 60;
  localparam int DB_W       = 20;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SPLIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_SPLIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DET_ATTACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DET_REL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ATT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd7;

  localparam logic [9:0]  RST_NOISE      = 10'd0;
  localparam logic [15:0] RST_LOW_SPLIT  = 16'd1526;
  localparam logic [15:0] RST_MID_SPLIT  = 16'd18901;
  localparam logic [15:0] RST_DET_ATTACK = 16'd64408;
  localparam logic [15:0] RST_DET_REL    = 16'd65520;
  localparam logic [15:0] RST_GAIN_ATT   = 16'd63852;
  localparam logic [15:0] RST_GAIN_REL   = 16'd65528;
  localparam logic [13:0] RST_HOLD       = 14'd2160;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic [9:0] AMOUNT_MAX = 10'd1000;

  // levels in 1/256 dB
  localparam logic signed [DB_W-1:0] DB_FLOOR   = -20'sd30720;
  localparam logic signed [DB_W-1:0] OPEN_BASE  = -20'sd19968;
  localparam logic signed [DB_W-1:0] FLOOR_BASE = -20'sd4608;
  localparam logic signed [DB_W-1:0] HYST_DB    = 20'sd1536;
  localparam logic signed [DB_W-1:0] BAND_OFS   = 20'sd512;
  localparam logic [MA_W-1:0] OPEN_SPAN  = 33'd11776;
  localparam logic [MA_W-1:0] FLOOR_SPAN = 33'd13824;
  localparam logic [MA_W-1:0] HALF_1000  = 33'd500;

  localparam logic [MB_W-1:0] DB_PER_LOG2 = 27'd101008905;
  localparam logic [MB_W-1:0] LOG2_PER_DB = 27'd2786637;
  // floor(x/1000) = (x*RECIP_1000) >> 34, floor(x/10) = (x*RECIP_10) >> 23
  localparam logic [MB_W-1:0] RECIP_1000  = 27'd17179870;
  localparam logic [MB_W-1:0] RECIP_10    = 27'd838861;

  typedef enum logic [26:0] {
    ST_IDLE  = 27'h0000001,
    ST_DET   = 27'h0000002,
    ST_WT    = 27'h0000004,
    ST_LOWU  = 27'h0000008,
    ST_MIDU  = 27'h0000010,
    ST_BAND  = 27'h0000020,
    ST_ENVS  = 27'h0000040,
    ST_ENVU  = 27'h0000080,
    ST_NRM   = 27'h0000100,
    ST_LIX   = 27'h0000200,
    ST_LRD   = 27'h0000400,
    ST_LDB   = 27'h0000800,
    ST_CAND  = 27'h0001000,
    ST_OPN   = 27'h0002000,
    ST_OPNU  = 27'h0004000,
    ST_FLRU  = 27'h0008000,
    ST_HYS   = 27'h0010000,
    ST_CLSU  = 27'h0020000,
    ST_LNU   = 27'h0040000,
    ST_ERD   = 27'h0080000,
    ST_EGN   = 27'h0100000,
    ST_GSM   = 27'h0200000,
    ST_GSU   = 27'h0400000,
    ST_OUTL  = 27'h0800000,
    ST_OUTLU = 27'h1000000,
    ST_OUTRU = 27'h2000000,
    ST_FIN   = 27'h4000000
  } state_t;

endpackage
`default_nettype wire

// ===== sv/three_band_noise_gate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata: left_in, right_in
// m_*       out  m_tvalid/m_tready    m_tdata: left_out, right_out, gate_gain; m_tuser: open
// cfg_*     in   cfg_we               cfg_index, cfg_wdata
// bypass (noise amount zero) sends the input straight to the output register; the main products
// go through one shared 33x27 multiplier, loaded in a setup state and read after the wait state
// ST_WT; a nonzero band level adds a 5-step normalizer and log lookup, a closed gate an exp lookup.
// s_tready is high only in the idle state; one word is worked on at a time.
// a finished word waits in the output register while the next word is accepted.
// rst is synchronous: registers to reset values, gain unity, gate open.
module three_band_noise_gate_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tbng_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbng_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // left_in, right_in
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2*SAMPLE_BITS+tbng_pkg::GAIN_W+7)/8)*8-1:0] m_tdata, // left_out, right_out, gate_gain
  output logic [0:0] m_tuser // gate_is_open
);
  import tbng_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int OUT_TDW = ((2*SAMPLE_BITS+GAIN_W+7)/8)*8;
  localparam int IW = $clog2(LOG_TABLE_DEPTH);
  localparam int LSH = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
  localparam int RSH = (SAMPLE_BITS > 31) ? 1 : 0;
  localparam logic [63:0] Q30 = 64'd1073741824;

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) if (b > v) b = b >> 2;
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] log_entry(int i);
    logic [63:0] x;
    logic [15:0] fr;
    x = Q30 + ((64'(i) << 30) / LOG_TABLE_DEPTH);
    fr = 16'd0;
    for (int j = 0; j < 16; j++) begin
      x = (x * x) >> 30;
      fr = {fr[14:0], 1'b0};
      if (x >= 2 * Q30) begin
        fr[0] = 1'b1;
        x = x >> 1;
      end
    end
    return fr;
  endfunction

  function automatic logic [31:0] exp_entry(int i);
    logic [63:0] roots [17];
    logic [63:0] r, acc, f;
    roots[0] = Q30;
    r = 2 * Q30;
    for (int j = 1; j <= 16; j++) begin
      r = isqrt64(r << 30);
      roots[j] = r;
    end
    acc = roots[0];
    f = (64'(i) << 16) / LOG_TABLE_DEPTH;
    for (int j = 1; j <= 16; j++) if (f[16-j]) acc = (acc * roots[j] + (Q30 >> 1)) >> 30;
    return acc[31:0];
  endfunction

  logic [15:0] log_rom [LOG_TABLE_DEPTH];
  logic [31:0] exp_rom [LOG_TABLE_DEPTH];
  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_rom
    assign log_rom[g] = log_entry(g);
    assign exp_rom[g] = exp_entry(g);
  end

  // configuration
  logic [9:0]  noise;
  logic [15:0] low_coef, mid_coef, det_att, det_rel, gain_att, gain_rel;
  logic [13:0] hold_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise    <= RST_NOISE;
      low_coef <= RST_LOW_SPLIT;
      mid_coef <= RST_MID_SPLIT;
      det_att  <= RST_DET_ATTACK;
      det_rel  <= RST_DET_REL;
      gain_att <= RST_GAIN_ATT;
      gain_rel <= RST_GAIN_REL;
      hold_cfg <= RST_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOISE:      noise    <= cfg_wdata[9:0];
        REG_LOW_SPLIT:  low_coef <= cfg_wdata;
        REG_MID_SPLIT:  mid_coef <= cfg_wdata;
        REG_DET_ATTACK: det_att  <= cfg_wdata;
        REG_DET_REL:    det_rel  <= cfg_wdata;
        REG_GAIN_ATT:   gain_att <= cfg_wdata;
        REG_GAIN_REL:   gain_rel <= cfg_wdata;
        REG_HOLD:       hold_cfg <= cfg_wdata[13:0];
        default:        ;
      endcase
    end
  end

  state_t state, ret;
  logic signed [SB-1:0] ls, rs, det, low, mid, res_l, res_r;
  logic [31:0] env [3];
  logic [31:0] lvr, nm, erom;
  logic [GAIN_W-1:0] g, target, res_gain;
  logic [13:0] hold;
  logic open_f, res_open, lzero, gneg, gnz, msgn;
  logic [1:0] band;
  logic [4:0] sc;
  logic [2:0] nstep;
  logic [6:0] kreg;
  logic [15:0] lrom;
  logic signed [DB_W-1:0] act, open_db, floor_db;
  logic [MA_W-1:0] ma;
  logic [MB_W-1:0] mb;
  logic [P_W-1:0] prod;

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= {27'd0, ma} * {33'd0, mb};
  end

  logic [43:0] p16;
  logic [27:0] p32;
  logic signed [44:0] s16;
  logic signed [28:0] s32;
  always_comb begin
    p16 = 44'((prod + 60'd32768) >> 16);
    p32 = 28'((prod + 60'h80000000) >> 32);
    s16 = msgn ? -$signed({1'b0, p16}) : $signed({1'b0, p16});
    s32 = msgn ? -$signed({1'b0, p32}) : $signed({1'b0, p32});
  end

  logic signed [SB-1:0] in_l, in_r;
  logic [SB:0] mag_l, mag_r, abs_ls, abs_rs;
  logic [9:0] nc;
  assign in_l = $signed(s_tdata[SB-1:0]);
  assign in_r = $signed(s_tdata[2*SB-1:SB]);
  assign mag_l = in_l[SB-1] ? $unsigned(-{in_l[SB-1], in_l}) : $unsigned({in_l[SB-1], in_l});
  assign mag_r = in_r[SB-1] ? $unsigned(-{in_r[SB-1], in_r}) : $unsigned({in_r[SB-1], in_r});
  assign abs_ls = ls[SB-1] ? $unsigned(-{ls[SB-1], ls}) : $unsigned({ls[SB-1], ls});
  assign abs_rs = rs[SB-1] ? $unsigned(-{rs[SB-1], rs}) : $unsigned({rs[SB-1], rs});
  assign nc = (noise > AMOUNT_MAX) ? AMOUNT_MAX : noise;

  // lowpass and band differences
  logic signed [SB:0] lp_low, lp_mid, bdiff;
  logic [SB:0] lp_low_abs, lp_mid_abs, bmag;
  always_comb begin
    lp_low = {det[SB-1], det} - {low[SB-1], low};
    lp_mid = {det[SB-1], det} - {mid[SB-1], mid};
    case (band)
      2'd0:    bdiff = {low[SB-1], low};
      2'd1:    bdiff = {mid[SB-1], mid} - {low[SB-1], low};
      default: bdiff = lp_mid;
    endcase
    lp_low_abs = lp_low[SB] ? $unsigned(-lp_low) : $unsigned(lp_low);
    lp_mid_abs = lp_mid[SB] ? $unsigned(-lp_mid) : $unsigned(lp_mid);
    bmag = bdiff[SB] ? $unsigned(-bdiff) : $unsigned(bdiff);
  end

  // envelope and log path
  logic signed [32:0] ediff;
  logic [31:0] env_new;
  logic [5:0] nsh;
  logic signed [6:0] lexp;
  logic signed [23:0] l2;
  logic [IW:0] lidx_raw, eidx_raw;
  logic [IW-1:0] lidx, eidx;
  logic signed [DB_W-1:0] db_cl, cand;
  always_comb begin
    ediff = $signed({1'b0, lvr}) - $signed({1'b0, env[band]});
    env_new = env[band] + 32'(s16);
    nsh = 6'd16 >> nstep;
    lexp = 7'sd1 - $signed({2'b00, sc});
    l2 = $signed({lexp[6], lexp, 16'h0000}) + $signed({8'h00, lrom});
    lidx_raw = prod[30 +: IW+1];
    eidx_raw = prod[16 +: IW+1];
    lidx = (lidx_raw >= (IW+1)'(LOG_TABLE_DEPTH)) ? IW'(LOG_TABLE_DEPTH - 1) : lidx_raw[IW-1:0];
    eidx = (eidx_raw >= (IW+1)'(LOG_TABLE_DEPTH)) ? IW'(LOG_TABLE_DEPTH - 1) : eidx_raw[IW-1:0];
    if (lzero) db_cl = DB_FLOOR;
    else if (s32 < DB_FLOOR) db_cl = DB_FLOOR;
    else db_cl = DB_W'(s32);
    case (band)
      2'd0:    cand = db_cl - BAND_OFS;
      2'd1:    cand = db_cl;
      default: cand = db_cl + BAND_OFS;
    endcase
  end

  // hysteresis, closed gain and smoothing
  logic signed [DB_W-1:0] close_db, below_s, nfl;
  logic [18:0] below_u;
  logic [16:0] qc;
  logic [DB_W-1:0] neg_c;
  logic [21:0] ln;
  logic [6:0] kval;
  logic [15:0] fval;
  logic [7:0] esh;
  logic [63:0] etg;
  logic signed [17:0] gdiff;
  logic [17:0] st, st1;
  logic signed [19:0] ng;
  logic [15:0] gcoef;
  always_comb begin
    close_db = open_db - HYST_DB;
    below_s = close_db - act;
    below_u = below_s[DB_W-1] ? 19'd0 : below_s[18:0];
    qc = prod[23 +: 17];
    nfl = -floor_db;
    neg_c = ($signed({3'b000, qc}) < nfl) ? {3'b000, qc} : $unsigned(nfl);
    ln = p16[21:0];
    kval = 7'((23'(ln) + 23'd65535) >> 16);
    fval = 16'(-ln[15:0]);
    esh = 8'd14 + 8'(kreg);
    etg = (64'(erom) + (64'd1 << (esh - 8'd1))) >> esh;
    gdiff = $signed({1'b0, target}) - $signed({1'b0, g});
    gcoef = (target > g) ? gain_att : gain_rel;
    st = prod[16 +: 18];
    st1 = (st == 18'd0 && gnz) ? 18'd1 : st;
    ng = gneg ? $signed({3'b000, g}) - $signed({2'b00, st1})
              : $signed({3'b000, g}) + $signed({2'b00, st1});
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      m_tvalid <= 1'b0;
      low      <= '0;
      mid      <= '0;
      env[0]   <= 32'd0;
      env[1]   <= 32'd0;
      env[2]   <= 32'd0;
      g        <= GAIN_ONE;
      hold     <= 14'd0;
      open_f   <= 1'b1;
      band     <= 2'd0;
      nstep    <= 3'd0;
    end else begin
      // the final state reloads the output register itself
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ls  <= in_l;
            rs  <= in_r;
            det <= (mag_r > mag_l) ? in_r : in_l;
            act <= DB_FLOOR;
            if (noise == 10'd0) begin
              low      <= '0;
              mid      <= '0;
              env[0]   <= 32'd0;
              env[1]   <= 32'd0;
              env[2]   <= 32'd0;
              g        <= GAIN_ONE;
              hold     <= 14'd0;
              open_f   <= 1'b1;
              res_l    <= in_l;
              res_r    <= in_r;
              res_open <= 1'b1;
              res_gain <= GAIN_ONE;
              state    <= ST_FIN;
            end else begin
              state <= ST_DET;
            end
          end
        end
        ST_DET: begin
          ma    <= MA_W'(lp_low_abs);
          mb    <= MB_W'(low_coef);
          msgn  <= lp_low[SB];
          ret   <= ST_LOWU;
          state <= ST_WT;
        end
        ST_WT: state <= ret;
        ST_LOWU: begin
          low   <= low + SB'(s16);
          ma    <= MA_W'(lp_mid_abs);
          mb    <= MB_W'(mid_coef);
          msgn  <= lp_mid[SB];
          ret   <= ST_MIDU;
          state <= ST_WT;
        end
        ST_MIDU: begin
          mid   <= mid + SB'(s16);
          band  <= 2'd0;
          state <= ST_BAND;
        end
        ST_BAND: begin
          lvr   <= 32'((64'(bmag) << LSH) >> RSH);
          state <= ST_ENVS;
        end
        ST_ENVS: begin
          ma    <= ediff[32] ? MA_W'($unsigned(-ediff)) : MA_W'($unsigned(ediff));
          mb    <= MB_W'(GAIN_ONE - {1'b0, (lvr > env[band]) ? det_att : det_rel});
          msgn  <= ediff[32];
          ret   <= ST_ENVU;
          state <= ST_WT;
        end
        ST_ENVU: begin
          env[band] <= env_new;
          nm        <= env_new;
          sc        <= 5'd0;
          nstep     <= 3'd0;
          lzero     <= (env_new == 32'd0);
          state     <= (env_new == 32'd0) ? ST_CAND : ST_NRM;
        end
        ST_NRM: begin
          // binary search for the leading one: shifts of 16, 8, 4, 2, 1
          if ((nm >> (6'd32 - nsh)) == 32'd0) begin
            nm <= nm << nsh;
            sc <= sc + 5'(nsh);
          end
          nstep <= nstep + 3'd1;
          if (nstep == 3'd4) state <= ST_LIX;
        end
        ST_LIX: begin
          ma    <= {3'b000, nm[30:1]};
          mb    <= MB_W'(LOG_TABLE_DEPTH);
          msgn  <= 1'b0;
          ret   <= ST_LRD;
          state <= ST_WT;
        end
        ST_LRD: begin
          lrom  <= log_rom[lidx];
          state <= ST_LDB;
        end
        ST_LDB: begin
          ma    <= l2[23] ? MA_W'($unsigned(-l2)) : MA_W'($unsigned(l2));
          mb    <= DB_PER_LOG2;
          msgn  <= l2[23];
          ret   <= ST_CAND;
          state <= ST_WT;
        end
        ST_CAND: begin
          if (cand > act) act <= cand;
          band <= band + 2'd1;
          state <= (band == 2'd2) ? ST_OPN : ST_BAND;
        end
        ST_OPN: begin
          ma    <= MA_W'(nc) * OPEN_SPAN + HALF_1000;
          mb    <= RECIP_1000;
          ret   <= ST_OPNU;
          state <= ST_WT;
        end
        ST_OPNU: begin
          open_db <= OPEN_BASE + $signed({5'b00000, prod[34 +: 15]});
          ma      <= MA_W'(nc) * FLOOR_SPAN + HALF_1000;
          mb      <= RECIP_1000;
          ret     <= ST_FLRU;
          state   <= ST_WT;
        end
        ST_FLRU: begin
          floor_db <= FLOOR_BASE - $signed({5'b00000, prod[34 +: 15]});
          state    <= ST_HYS;
        end
        ST_HYS: begin
          if (act >= open_db) begin
            open_f <= 1'b1;
            hold   <= hold_cfg;
          end else if (hold != 14'd0) begin
            hold <= hold - 14'd1;
          end else if (act < close_db) begin
            open_f <= 1'b0;
          end
          ma    <= MA_W'(below_u) * 33'd22 + 33'd5;
          mb    <= RECIP_10;
          ret   <= ST_CLSU;
          state <= ST_WT;
        end
        ST_CLSU: begin
          if (open_f) begin
            target <= GAIN_ONE;
            state  <= ST_GSM;
          end else begin
            ma    <= MA_W'(neg_c);
            mb    <= LOG2_PER_DB;
            ret   <= ST_LNU;
            state <= ST_WT;
          end
        end
        ST_LNU: begin
          kreg  <= kval;
          ma    <= MA_W'(fval);
          mb    <= MB_W'(LOG_TABLE_DEPTH);
          ret   <= ST_ERD;
          state <= ST_WT;
        end
        ST_ERD: begin
          erom  <= exp_rom[eidx];
          state <= ST_EGN;
        end
        ST_EGN: begin
          target <= (kreg > 7'd40) ? 17'd0 : 17'(etg);
          state  <= ST_GSM;
        end
        ST_GSM: begin
          ma    <= gdiff[17] ? MA_W'($unsigned(-gdiff)) : MA_W'($unsigned(gdiff));
          mb    <= MB_W'(GAIN_ONE - {1'b0, gcoef});
          gneg  <= gdiff[17];
          gnz   <= (gdiff != 18'sd0);
          ret   <= ST_GSU;
          state <= ST_WT;
        end
        ST_GSU: begin
          if (ng < 20'sd0) g <= 17'd0;
          else if (ng > $signed({3'b000, GAIN_ONE})) g <= GAIN_ONE;
          else g <= ng[16:0];
          state <= ST_OUTL;
        end
        ST_OUTL: begin
          ma    <= MA_W'(abs_ls);
          mb    <= MB_W'(g);
          msgn  <= ls[SB-1];
          ret   <= ST_OUTLU;
          state <= ST_WT;
        end
        ST_OUTLU: begin
          res_l <= SB'(s16);
          ma    <= MA_W'(abs_rs);
          mb    <= MB_W'(g);
          msgn  <= rs[SB-1];
          ret   <= ST_OUTRU;
          state <= ST_WT;
        end
        ST_OUTRU: begin
          res_r    <= SB'(s16);
          res_open <= open_f;
          res_gain <= g;
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_TDW'({res_gain, res_r, res_l});
            m_tuser  <= res_open;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/tbng_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tbng_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((2*SAMPLE_BITS+tbng_pkg::GAIN_W+7)/8)*8-1:0] m_tdata,
  input wire logic [0:0] m_tuser
);
  import tbng_pkg::*;

  // words accepted but not yet delivered
  logic [1:0] pending;
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2*SAMPLE_BITS +: GAIN_W] <= GAIN_ONE))
    else $error("gain above unity");

  a_pending: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd3) && (!m_tvalid || pending != 2'd0))
    else $error("output words do not match accepted words");

endmodule

bind three_band_noise_gate_core tbng_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tbng_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
